>>> src/mtmf_pkg.sv
// ----------------------------------------------------------------------------
// mtmf_pkg
// Shared types and constants for the threshold median projection block:
// channel payloads, register map, controller states and command/status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package mtmf_pkg;

   // operation codes
   localparam logic [1:0] OP_ACCUM = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // plane selector codes (anything else acts as XY)
   localparam logic [1:0] PLANE_XY = 2'd0;
   localparam logic [1:0] PLANE_XZ = 2'd1;
   localparam logic [1:0] PLANE_YZ = 2'd2;

   // register map, index = paddr[4:2]
   localparam int         CSR_AW       = 5;
   localparam logic [2:0] REG_PLANE    = 3'd0;
   localparam logic [2:0] REG_THRESH   = 3'd1;
   localparam logic [2:0] REG_SIZE_X   = 3'd2;
   localparam logic [2:0] REG_SIZE_Y   = 3'd3;
   localparam logic [2:0] REG_SIZE_Z   = 3'd4;

   localparam logic [8:0] SIZE_RESET   = 9'd256;

   // binarised pixel levels
   localparam logic [7:0] FG_VALUE = 8'd255;
   localparam logic [7:0] BG_VALUE = 8'd0;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] coord_x;
      logic [7:0] coord_y;
      logic [7:0] coord_z;
      logic [7:0] voxel_value;
   } mtmf_req_type;

   typedef struct packed {
      logic [7:0] filtered_pixel;
      logic [7:0] projected_value;
      logic       out_of_range;
   } mtmf_rsp_type;

   typedef struct packed {
      logic [1:0] plane;
      logic [7:0] threshold;
      logic [8:0] size_x;
      logic [8:0] size_y;
      logic [8:0] size_z;
   } mtmf_cfg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_WIN,
      ST_WIN_END,
      ST_RESULT
   } mtmf_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_item;
      logic clear_wr;
      logic acc_wr;
      logic win_rd;
      logic result_ld;
   } mtmf_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] req_op;
      logic       req_inside;
      logic       clear_last;
      logic       scan_last;
      logic       out_free;
   } mtmf_sts_type;

endpackage

`default_nettype wire

>>> src/mtmf_csr.sv
// ----------------------------------------------------------------------------
// mtmf_csr
// APB-style register file: plane select, threshold and volume sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module mtmf_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [mtmf_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]                csr_pwdata,
   output logic      [31:0]                csr_prdata,
   output logic                            csr_pready,
   output mtmf_pkg::mtmf_cfg_type          cfg
);
   import mtmf_pkg::*;

   mtmf_cfg_type cfg_ff, cfg_in;
   logic [2:0]   reg_idx;
   logic         wr_en;

   assign reg_idx    = csr_paddr[CSR_AW-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_PLANE:  cfg_in.plane     = csr_pwdata[1:0];
            REG_THRESH: cfg_in.threshold = csr_pwdata[7:0];
            REG_SIZE_X: cfg_in.size_x    = csr_pwdata[8:0];
            REG_SIZE_Y: cfg_in.size_y    = csr_pwdata[8:0];
            REG_SIZE_Z: cfg_in.size_z    = csr_pwdata[8:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PLANE:  csr_prdata = 32'(cfg_ff.plane);
         REG_THRESH: csr_prdata = 32'(cfg_ff.threshold);
         REG_SIZE_X: csr_prdata = 32'(cfg_ff.size_x);
         REG_SIZE_Y: csr_prdata = 32'(cfg_ff.size_y);
         REG_SIZE_Z: csr_prdata = 32'(cfg_ff.size_z);
         default:    csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.plane     <= PLANE_XY;
         cfg_ff.threshold <= 8'd0;
         cfg_ff.size_x    <= SIZE_RESET;
         cfg_ff.size_y    <= SIZE_RESET;
         cfg_ff.size_z    <= SIZE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> src/mtmf_ctrl.sv
// ----------------------------------------------------------------------------
// mtmf_ctrl
// Sequencer: clearing sweep, read-modify-write accumulate, 3x3 window scan
// and result hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtmf_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire mtmf_pkg::mtmf_sts_type sts,
   output mtmf_pkg::mtmf_cmd_type      cmd
);
   import mtmf_pkg::*;

   mtmf_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;   // store is swept to zero after reset
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               case (sts.req_op)
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_ACCUM: state_in = sts.req_inside ? ST_ACC_RD : ST_RESULT;
                  OP_READ:  state_in = sts.req_inside ? ST_WIN : ST_RESULT;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_ACC_RD: begin
            state_in = ST_ACC_WR;
         end
         ST_ACC_WR: begin
            cmd.acc_wr = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_WIN: begin
            cmd.win_rd = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_WIN_END;
            end
         end
         ST_WIN_END: begin
            // last tap's read data is counted in this cycle
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (sts.out_free) begin
               cmd.result_ld = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> src/mtmf_dp.sv
// ----------------------------------------------------------------------------
// mtmf_dp
// Datapath: plane mapping and range check, frame store with one read and one
// write port, window tap generator, foreground counters and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtmf_dp #(
   parameter int MAX_DIM = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mtmf_pkg::mtmf_cfg_type cfg,
   input  wire mtmf_pkg::mtmf_req_type req_data,
   input  wire logic                   rsp_stall,
   input  wire mtmf_pkg::mtmf_cmd_type cmd,
   output mtmf_pkg::mtmf_sts_type      sts,
   output logic                        rsp_valid,
   output mtmf_pkg::mtmf_rsp_type      rsp_data
);
   import mtmf_pkg::*;

   localparam int DIM_W     = $clog2(MAX_DIM);
   localparam int AW        = 2 * DIM_W;
   localparam int MEM_DEPTH = 1 << AW;
   localparam int SW        = ($clog2(MAX_DIM + 1) > 9) ? $clog2(MAX_DIM + 1) : 9;
   localparam int CW        = (DIM_W > 9) ? DIM_W : 9;
   localparam logic [SW-1:0] DIM_LIMIT = SW'(MAX_DIM);
   localparam logic [1:0]    TAP_LAST  = 2'd2;
   localparam logic [1:0]    TAP_MID   = 2'd1;

   // ---- plane mapping of the incoming item ----
   logic [SW-1:0] eff_x, eff_y, eff_z;
   logic [7:0]    req_u, req_v;
   logic [SW-1:0] req_su, req_sv;
   logic          req_inside;

   assign eff_x = (SW'(cfg.size_x) > DIM_LIMIT) ? DIM_LIMIT : SW'(cfg.size_x);
   assign eff_y = (SW'(cfg.size_y) > DIM_LIMIT) ? DIM_LIMIT : SW'(cfg.size_y);
   assign eff_z = (SW'(cfg.size_z) > DIM_LIMIT) ? DIM_LIMIT : SW'(cfg.size_z);

   always_comb begin
      case (cfg.plane)
         PLANE_XZ: begin
            req_u = req_data.coord_x; req_su = eff_x;
            req_v = req_data.coord_z; req_sv = eff_z;
         end
         PLANE_YZ: begin
            req_u = req_data.coord_y; req_su = eff_y;
            req_v = req_data.coord_z; req_sv = eff_z;
         end
         default: begin
            req_u = req_data.coord_x; req_su = eff_x;
            req_v = req_data.coord_y; req_sv = eff_y;
         end
      endcase
   end

   assign req_inside = (SW'(req_u) < req_su) && (SW'(req_v) < req_sv);

   // ---- item registers ----
   logic [7:0]    u_ff, v_ff, val_ff;
   logic [SW-1:0] su_ff, sv_ff;
   logic          inside_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         u_ff      <= req_u;
         v_ff      <= req_v;
         su_ff     <= req_su;
         sv_ff     <= req_sv;
         val_ff    <= req_data.voxel_value;
         inside_ff <= req_inside;
      end
   end

   // ---- window tap generator ----
   logic [1:0]    di_ff, dj_ff, di_in, dj_in;
   logic [CW-1:0] ti, tj, uc, vc;
   logic          tap_ok, scan_last;
   logic [AW-1:0] tap_addr, ctr_addr, rd_addr;

   assign ti = CW'(u_ff) + CW'(di_ff) - CW'(1);
   assign tj = CW'(v_ff) + CW'(dj_ff) - CW'(1);
   assign uc = CW'(u_ff);
   assign vc = CW'(v_ff);

   // window clipped at the plane edges
   assign tap_ok = ((di_ff != 2'd0) || (u_ff != 8'd0)) && (SW'(ti) < su_ff) &&
                   ((dj_ff != 2'd0) || (v_ff != 8'd0)) && (SW'(tj) < sv_ff);

   assign tap_addr  = {tj[DIM_W-1:0], ti[DIM_W-1:0]};
   assign ctr_addr  = {vc[DIM_W-1:0], uc[DIM_W-1:0]};
   assign rd_addr   = cmd.win_rd ? tap_addr : ctr_addr;
   assign scan_last = (di_ff == TAP_LAST) && (dj_ff == TAP_LAST);

   always_comb begin
      di_in = di_ff;
      dj_in = dj_ff;
      if (cmd.load_item) begin
         di_in = 2'd0;
         dj_in = 2'd0;
      end else if (cmd.win_rd) begin
         if (di_ff == TAP_LAST) begin
            di_in = 2'd0;
            dj_in = dj_ff + 2'd1;
         end else begin
            di_in = di_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      di_ff <= di_in;
      dj_ff <= dj_in;
   end

   // ---- frame store ----
   logic [7:0]    mem [MEM_DEPTH];
   logic [7:0]    rdata_ff;
   logic [7:0]    acc_max;
   logic [AW-1:0] clr_ff, clr_in;

   assign acc_max = (val_ff > rdata_ff) ? val_ff : rdata_ff;
   assign clr_in  = cmd.clear_wr ? clr_ff + AW'(1) : clr_ff;

   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         mem[clr_ff] <= BG_VALUE;
      end else if (cmd.acc_wr) begin
         mem[ctr_addr] <= acc_max;
      end
      rdata_ff <= mem[rd_addr];
   end

   // sweep counter wraps to zero after the last entry
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // ---- foreground counting, one tap behind the read ----
   logic       tap_ok_ff, tap_ctr_ff, tap_ok_in, tap_ctr_in;
   logic [3:0] n_ff, fg_ff, n_in, fg_in;
   logic [7:0] proj_ff, proj_in;

   assign tap_ok_in  = cmd.win_rd & tap_ok;
   assign tap_ctr_in = cmd.win_rd & (di_ff == TAP_MID) & (dj_ff == TAP_MID);

   always_comb begin
      n_in    = n_ff;
      fg_in   = fg_ff;
      proj_in = proj_ff;
      if (cmd.load_item) begin
         n_in    = 4'd0;
         fg_in   = 4'd0;
         proj_in = BG_VALUE;
      end else begin
         if (tap_ok_ff) begin
            n_in = n_ff + 4'd1;
            if (rdata_ff > cfg.threshold) begin
               fg_in = fg_ff + 4'd1;
            end
         end
         if (tap_ctr_ff) begin
            proj_in = rdata_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ok_ff  <= 1'b0;
         tap_ctr_ff <= 1'b0;
      end else begin
         tap_ok_ff  <= tap_ok_in;
         tap_ctr_ff <= tap_ctr_in;
      end
      n_ff    <= n_in;
      fg_ff   <= fg_in;
      proj_ff <= proj_in;
   end

   // ---- result and output register ----
   logic [7:0]   median;
   mtmf_rsp_type rsp_in;
   mtmf_rsp_type rsp_data_ff;
   logic         rsp_valid_ff, rsp_valid_in, out_free;

   // upper median of a binary set: foreground once 2*fg >= n
   assign median = ({fg_ff, 1'b0} >= {1'b0, n_ff}) ? FG_VALUE : BG_VALUE;

   always_comb begin
      if (inside_ff) begin
         rsp_in.filtered_pixel  = median;
         rsp_in.projected_value = proj_ff;
         rsp_in.out_of_range    = 1'b0;
      end else begin
         rsp_in.filtered_pixel  = BG_VALUE;
         rsp_in.projected_value = BG_VALUE;
         rsp_in.out_of_range    = 1'b1;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.result_ld) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.result_ld) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---- status ----
   assign sts.req_op     = req_data.operation;
   assign sts.req_inside = req_inside;
   assign sts.clear_last = &clr_ff;
   assign sts.scan_last  = scan_last;
   assign sts.out_free   = out_free;

endmodule

`default_nettype wire

>>> src/mip_threshold_median_filter.sv
// ----------------------------------------------------------------------------
// mip_threshold_median_filter
// Maximum intensity projection of a voxel stream with a thresholded 3x3
// binary median readout.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (valid/stall) carries one transaction per operation:
//    accumulate a voxel, read a plane pixel, or clear the frame store.
//  - rsp channel (valid/stall) returns one transaction for every read and
//    for every accumulate whose plane coordinates fall outside the sizes.
//  - csr port (APB-style) holds plane select, threshold and volume sizes;
//    write it only while the block is idle.
// Operation sequences (accept to next possible accept):
//  - accumulate, in range: store read, max, write back.
//  - out-of-range request: result loaded into the output register once it is free.
//  - read: nine window taps go through the single store read port one per
//    cycle, then the result is loaded into the output register.
//  - clear: every store entry is set to zero, one entry per cycle through
//    the store write port. Reset runs the same sweep, with req_stall high
//    throughout; csr writes are taken meanwhile.
// A finished result waits in the output register while rsp_stall is high;
// the next transaction is still accepted and only blocks once it has its
// own result ready.
// ----------------------------------------------------------------------------
`default_nettype none

module mip_threshold_median_filter #(
   parameter int MAX_DIM = 256
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire mtmf_pkg::mtmf_req_type      req_data,
   // response channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output mtmf_pkg::mtmf_rsp_type           rsp_data,
   // configuration port
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [mtmf_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]                 csr_pwdata,
   output logic      [31:0]                 csr_prdata,
   output logic                             csr_pready
);
   import mtmf_pkg::*;

   mtmf_cfg_type cfg;
   mtmf_cmd_type cmd;
   mtmf_sts_type sts;

   // register file
   mtmf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer; owns req_stall
   mtmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // frame store, window scan and output register
   mtmf_dp #(
      .MAX_DIM (MAX_DIM)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> src/mtmf_checker.sv
// ----------------------------------------------------------------------------
// mtmf_checker
// Port-level checks on the response channel and the post-reset sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module mtmf_checker (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire mtmf_pkg::mtmf_rsp_type rsp_data
);
   import mtmf_pkg::*;

   // store sweep blocks requests right after reset
   a_sweep_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("request taken during post-reset sweep");

   // out-of-range transactions carry zero pixels
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_of_range |->
         (rsp_data.filtered_pixel == BG_VALUE) &&
         (rsp_data.projected_value == BG_VALUE))
      else $error("out-of-range transaction with nonzero pixels");

   // filtered pixel is binary
   a_binary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.filtered_pixel == BG_VALUE) ||
         (rsp_data.filtered_pixel == FG_VALUE))
      else $error("filtered pixel not binary");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response transaction changed");

   // unused here beyond visibility of the request handshake
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$isunknown(req_stall))
      else $error("request stall unknown after a transaction");

endmodule

bind mip_threshold_median_filter mtmf_checker u_mtmf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
